// File: rtl/core/mlkc_pkg.sv
// Shared types, limits and helper functions for the multi-length k-mer counter.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package mlkc_pkg;

  localparam int unsigned KMER_LIMIT          = 12;
  localparam int unsigned HIST_LIMIT_W        = 2 * KMER_LIMIT;
  localparam int unsigned ADDR_LIMIT_W        = 25;
  localparam int unsigned CODE_W              = 2;
  localparam int unsigned DEF_MAX_KMER_LENGTH = 8;
  localparam int unsigned DEF_COUNT_WIDTH     = 32;

  localparam logic [1:0] CODE_MASK = 2'h3;
  localparam logic [1:0] CODE_A    = 2'd0;
  localparam logic [1:0] CODE_C    = 2'd1;
  localparam logic [1:0] CODE_G    = 2'd2;
  localparam logic [1:0] CODE_T    = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [7:0]  nucleotide;
    logic        read_start;
    logic [3:0]  query_length;
    logic [15:0] query_kmer;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kmer_count;
    logic        bad_symbol;
    logic        is_query_answer;
  } out_item_t;

  typedef struct packed {
    logic take;      // latch the input beat
    logic clr;       // write zero at the clear pointer and advance it
    logic rd;        // read the counter at the current address
    logic wr;        // write back the incremented counter
    logic step;      // advance to the next k-mer length
    logic load_out;  // load the output register
  } mlkc_cmd_t;

  typedef struct packed {
    logic is_query;
    logic last_len;
    logic clr_last;
  } mlkc_status_t;

  typedef struct packed {
    logic [1:0] code;
    logic       bad;
  } base_dec_t;

  function automatic base_dec_t decode_base(input logic [7:0] ch);
    base_dec_t d;
    d.bad  = 1'b0;
    d.code = CODE_A;
    case (ch)
      8'h41, 8'h61, 8'h4E, 8'h6E: d.code = CODE_A;
      8'h43, 8'h63:               d.code = CODE_C;
      8'h47, 8'h67:               d.code = CODE_G;
      8'h54, 8'h74:               d.code = CODE_T;
      default: begin
        d.code = CODE_A;
        d.bad  = 1'b1;
      end
    endcase
    d.code = d.code & CODE_MASK;
    return d;
  endfunction

  // First address of the bank for length len: 4 + 16 + ... + 4^(len-1).
  function automatic logic [ADDR_LIMIT_W-1:0] bank_base(input logic [3:0] len);
    logic [ADDR_LIMIT_W-1:0] b;
    b = '0;
    for (int i = 1; i < KMER_LIMIT; i++) begin
      b[2*i] = (4'(i) < len);
    end
    return b;
  endfunction

  // Mask keeping the newest len bases.
  function automatic logic [HIST_LIMIT_W-1:0] len_mask(input logic [3:0] len);
    logic [HIST_LIMIT_W-1:0] m;
    m = '0;
    for (int i = 0; i < KMER_LIMIT; i++) begin
      m[2*i]   = (4'(i) < len);
      m[2*i+1] = (4'(i) < len);
    end
    return m;
  endfunction

endpackage

// File: rtl/core/mlkc_ctrl.sv
// Sequencing state machine of the k-mer counter.
// Depends on mlkc_pkg for the command and status structs.
`timescale 1ns / 1ps

module mlkc_ctrl import mlkc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  mlkc_status_t status_i,
  output mlkc_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = status_i.is_query ? ST_FIN : ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        if (status_i.last_len) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/mlkc_datapath.sv
// Datapath of the k-mer counter: base history, count memory, output register.
// Depends on mlkc_pkg; driven by commands from mlkc_ctrl.
`timescale 1ns / 1ps

module mlkc_datapath import mlkc_pkg::*; #(
  parameter int unsigned MAX_KMER_LENGTH = DEF_MAX_KMER_LENGTH,
  parameter int unsigned COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_data_i,
  input  mlkc_cmd_t    cmd_i,
  output mlkc_status_t status_o,
  output out_item_t    out_data_o
);

  localparam int unsigned STORE_DEPTH =
      ((1 << (2 * (MAX_KMER_LENGTH + 1))) - 4) / 3;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned HIST_W = 2 * MAX_KMER_LENGTH;
  localparam int unsigned LEN_W  = $clog2(MAX_KMER_LENGTH + 1);

  logic [COUNT_WIDTH-1:0] count_mem_q [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;

  logic [HIST_W-1:0] hist_q, hist_d, hist_base;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] clr_ptr_q;
  logic              op_q;
  logic              bad_q;
  logic              qok_q;
  logic [ADDR_W-1:0] qaddr_q, qaddr_d;
  out_item_t         out_q;

  base_dec_t         dec;
  logic [HIST_LIMIT_W-1:0] qlen_mask, clen_mask;
  logic [ADDR_LIMIT_W-1:0] qbank, cbank;
  logic [HIST_W-1:0] qmasked, cmasked;
  logic [ADDR_W-1:0] cnt_addr, cur_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] inc_data, wr_data;
  logic              mem_we;
  logic              qok;
  logic [31:0]       q_count;

  assign dec = decode_base(in_data_i.nucleotide);

  // Count path: history and fill after this base.
  always_comb begin
    hist_base = in_data_i.read_start ? '0 : hist_q;
    hist_d    = HIST_W'({hist_base, dec.code});
    if (in_data_i.read_start) begin
      fill_d = LEN_W'(1);
    end else if (fill_q == LEN_W'(MAX_KMER_LENGTH)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + LEN_W'(1);
    end
  end

  // Query path: bank base plus masked k-mer.
  assign qok = (in_data_i.query_length != 4'd0) &&
               ({1'b0, in_data_i.query_length} <= 5'(MAX_KMER_LENGTH));
  assign qlen_mask = len_mask(in_data_i.query_length);
  assign qbank     = bank_base(in_data_i.query_length);
  assign qmasked   = HIST_W'(in_data_i.query_kmer) & qlen_mask[HIST_W-1:0];
  assign qaddr_d   = qbank[ADDR_W-1:0] + ADDR_W'(qmasked);

  assign clen_mask = len_mask(4'(len_q));
  assign cbank     = bank_base(4'(len_q));
  assign cmasked   = hist_q & clen_mask[HIST_W-1:0];
  assign cnt_addr  = cbank[ADDR_W-1:0] + ADDR_W'(cmasked);
  assign cur_addr  = op_q ? qaddr_q : cnt_addr;

  assign inc_data = (&rd_data_q) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1);
  assign mem_we   = cmd_i.clr || cmd_i.wr;
  assign wr_addr  = cmd_i.clr ? clr_ptr_q : cur_addr;
  assign wr_data  = cmd_i.clr ? '0 : inc_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= count_mem_q[cur_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      fill_q    <= '0;
      len_q     <= '0;
      clr_ptr_q <= '0;
      op_q      <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
      end
      if (cmd_i.take) begin
        op_q  <= in_data_i.operation;
        len_q <= LEN_W'(1);
        if (!in_data_i.operation) begin
          hist_q <= hist_d;
          fill_q <= fill_d;
        end
      end else if (cmd_i.step) begin
        len_q <= len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      bad_q   <= dec.bad;
      qok_q   <= qok;
      qaddr_q <= qaddr_d;
    end
  end

  generate
    if (COUNT_WIDTH > 32) begin : g_sat
      assign q_count = (|rd_data_q[COUNT_WIDTH-1:32]) ? '1 : rd_data_q[31:0];
    end else begin : g_ext
      assign q_count = 32'(rd_data_q);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.kmer_count      <= (op_q && qok_q) ? q_count : 32'd0;
      out_q.bad_symbol      <= op_q ? 1'b0 : bad_q;
      out_q.is_query_answer <= op_q;
    end
  end

  assign status_o.is_query = op_q;
  assign status_o.last_len = (len_q == fill_q);
  assign status_o.clr_last = (clr_ptr_q == ADDR_W'(STORE_DEPTH - 1));
  assign out_data_o        = out_q;

endmodule

// File: rtl/core/multi_length_kmer_counter_unit.sv
// Flow: a count beat is acknowledged after a read and a write of the count memory for each
// k-mer length updated (bases seen in the read, at most MAX_KMER_LENGTH); a query reads once.
// Input stays stalled until a beat is handed to the output register, so a new beat enters
// only after the last one is done; each read-modify-write uses separate read and write states.
// Reset: asynchronous, active low; a clearing pass then zeroes all (4^(K+1)-4)/3 entries of
// the count memory (87380 at K=8), one entry a cycle, with input stalled until it ends.
`timescale 1ns / 1ps

module multi_length_kmer_counter_unit import mlkc_pkg::*; #(
  parameter int unsigned MAX_KMER_LENGTH = DEF_MAX_KMER_LENGTH,
  parameter int unsigned COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Command and status travel between the sequencer and the datapath only.
  mlkc_cmd_t    cmd;
  mlkc_status_t status;

  // Sequencer: clear pass, then accept a beat, walk the lengths, deliver.
  // The output register lets a new beat enter while a result still waits.
  mlkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: history shift, one bank per length laid out back to back in
  // one memory, saturating increment, output payload register.
  mlkc_datapath #(
    .MAX_KMER_LENGTH (MAX_KMER_LENGTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/core/mlkc_checker.sv
// Port-level checks for multi_length_kmer_counter_unit, with the bind that attaches them.
// Depends on mlkc_pkg for the beat structs.
`timescale 1ns / 1ps

module mlkc_checker import mlkc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Stall input right after an accepted beat while it is worked on.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while busy");

  // Count acknowledgements carry no count.
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_query_answer |-> out_data_o.kmer_count == 32'd0)
    else $error("count acknowledgement with nonzero count");

  // Query answers never flag a bad symbol.
  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_query_answer |-> !out_data_o.bad_symbol)
    else $error("query answer flagged bad symbol");

endmodule

bind multi_length_kmer_counter_unit mlkc_checker u_mlkc_checker (.*);
